// ----- hdl/rdr_pkg.sv -----
// shared constants for the radial distance ramp unit
package rdr_pkg;
  localparam int COORD_BITS_DEF = 10;
  localparam int LEVEL_BITS = 8;
  localparam int SCALE_BITS = 16;
  localparam logic [SCALE_BITS-1:0] FULL_SCALE_SQ = 16'd65025;
  localparam int CFG_INDEX_BITS = 3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CENTER_X = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CENTER_Y = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CENTER_Z = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_RADIUS = 3'd3;
endpackage

// ----- hdl/radial_distance_ramp_unit.sv -----
// radial distance ramp unit: voxel coordinate to 8-bit distance ramp level
// an accepted request moves through the front stages v1 to v4 and then the search stages to its done strobe
// throughput: one request per cycle, busy is never raised
// level found by an 8-step search, one bit per stage, one multiplier per stage
// reset clears the centre and radius registers and all pipeline valid bits
module radial_distance_ramp_unit #(
  parameter int COORD_BITS = rdr_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [COORD_BITS-1:0]              coord_x,
  input  logic [COORD_BITS-1:0]              coord_y,
  input  logic [COORD_BITS-1:0]              coord_z,
  output logic                               done,
  output logic [rdr_pkg::LEVEL_BITS-1:0]     level,
  input  logic                               cfg_we,
  input  logic [rdr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS:0]                cfg_data
);
  localparam int DW = COORD_BITS + 1;
  localparam int SQW = 2 * DW;
  localparam int SUMW = SQW + 2;
  localparam int NW = SUMW + rdr_pkg::SCALE_BITS;
  localparam int LB = rdr_pkg::LEVEL_BITS;
  localparam int STEPS = LB;

  logic [DW-1:0] center_x_doubled, center_y_doubled, center_z_doubled;
  logic [COORD_BITS-1:0] radius;
  logic [SQW-1:0] rsq4;

  logic v1, v2, v3, v4;
  logic [DW-1:0] dx, dy, dz;
  logic [SQW-1:0] qx, qy, qz;
  logic [SUMW-1:0] d2;
  logic [NW-1:0] n4;

  logic sv [0:STEPS];
  logic [NW-1:0] sn [0:STEPS];
  logic [NW-1:0] ss [0:STEPS];
  logic [LB-1:0] sl [0:STEPS];
  logic [NW-1:0] s_try [0:STEPS-1];
  logic [LB-1:0] l_try [0:STEPS-1];

  logic [DW-1:0] px, py, pz;

  assign busy = 1'b0;
  assign px = {coord_x, 1'b0};
  assign py = {coord_y, 1'b0};
  assign pz = {coord_z, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x_doubled <= '0;
      center_y_doubled <= '0;
      center_z_doubled <= '0;
      radius <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rdr_pkg::CFG_CENTER_X: center_x_doubled <= cfg_data;
        rdr_pkg::CFG_CENTER_Y: center_y_doubled <= cfg_data;
        rdr_pkg::CFG_CENTER_Z: center_z_doubled <= cfg_data;
        rdr_pkg::CFG_RADIUS: radius <= cfg_data[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // four times radius squared
  always_ff @(posedge clk) begin
    rsq4 <= {(SQW-2)'(radius) * (SQW-2)'(radius), 2'b00};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    dx <= (px >= center_x_doubled) ? px - center_x_doubled : center_x_doubled - px;
    dy <= (py >= center_y_doubled) ? py - center_y_doubled : center_y_doubled - py;
    dz <= (pz >= center_z_doubled) ? pz - center_z_doubled : center_z_doubled - pz;
    qx <= dx * dx;
    qy <= dy * dy;
    qz <= dz * dz;
    d2 <= SUMW'(qx) + SUMW'(qy) + SUMW'(qz);
    n4 <= NW'(d2) * NW'(rdr_pkg::FULL_SCALE_SQ);
  end

  assign sv[0] = v4;
  assign sn[0] = n4;
  assign ss[0] = '0;
  assign sl[0] = '0;

  // trial bit per stage: accept if 4 r^2 L^2 stays at or below 65025 d2
  always_comb begin
    for (int j = 0; j < STEPS; j++) begin
      l_try[j] = sl[j] | (LB'(1) << (STEPS - 1 - j));
      s_try[j] = ss[j] + ((NW'(rsq4) * NW'({1'b0, sl[j]} + {1'b0, l_try[j]}))
                 << (STEPS - 1 - j));
    end
  end

  for (genvar j = 0; j < STEPS; j++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        sv[j+1] <= 1'b0;
      end else begin
        sv[j+1] <= sv[j];
      end
      sn[j+1] <= sn[j];
      if (sn[j] >= s_try[j]) begin
        ss[j+1] <= s_try[j];
        sl[j+1] <= l_try[j];
      end else begin
        ss[j+1] <= ss[j];
        sl[j+1] <= sl[j];
      end
    end
  end

  assign done = sv[STEPS];
  assign level = sl[STEPS];

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##12 done) else $error("request lost in pipeline");
  a_front: assert property (@(posedge clk) disable iff (rst)
    v1 |=> v2) else $error("front stage valid dropped");
  a_search: assert property (@(posedge clk) disable iff (rst)
    v4 |=> sv[1]) else $error("search stage valid dropped");
endmodule
